/* design/wsts_pkg.sv */
// shared types and codes for the work-stealing task scheduler
package wsts_pkg;

    localparam logic [1:0] OP_ENQ   = 2'd0;
    localparam logic [1:0] OP_TAKE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int HEAVY_DIVISOR = 4;

    // worker count and task width are fixed by the port widths
    localparam int MAX_WORKERS = 8;
    localparam int TASK_BITS   = 16;

    // classified command, front to back
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] task_id;
        logic        heavy;
        logic        is_worker;
        logic [2:0]  worker;
    } cmd_t;

endpackage

/* design/wsts_front.sv */
// front part: captures commands into a short queue
module wsts_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  wsts_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output logic            not_empty,
    output wsts_pkg::cmd_t  head_cmd
);

    // two-entry queue
    wsts_pkg::cmd_t slot_reg [2];
    logic [1:0] count_reg;
    logic       rd_reg;
    logic       wr_reg;

    assign not_empty = (count_reg != 2'd0);
    assign head_cmd  = slot_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

/* design/wsts_back.sv */
// back part: queue state, memories and the take/enqueue sequencer
module wsts_back
#(
    parameter int DEQUE_DEPTH    = 16,
    parameter int INJECTOR_DEPTH = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [3:0]      active_workers,
    input  logic            cmd_valid,
    input  wsts_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    output logic            done,
    output logic [15:0]     given_task,
    output logic [1:0]      status,
    output logic [7:0]      queued_total
);

    localparam int MAX_WORKERS = wsts_pkg::MAX_WORKERS;
    localparam int TASK_BITS   = wsts_pkg::TASK_BITS;
    localparam int WB = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int DB = $clog2(DEQUE_DEPTH);
    localparam int IB = $clog2(INJECTOR_DEPTH);
    localparam int TOTAL_MAX = MAX_WORKERS * DEQUE_DEPTH + INJECTOR_DEPTH;
    localparam int TB = $clog2(TOTAL_MAX + 1);

    localparam logic [1:0] S_DECIDE = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_OUT    = 2'd2;

    logic [TASK_BITS-1:0] dq_mem [MAX_WORKERS*DEQUE_DEPTH];
    logic [TASK_BITS-1:0] inj_mem [INJECTOR_DEPTH];

    logic [DB-1:0] head_reg [MAX_WORKERS];
    logic [DB:0]   fill_reg [MAX_WORKERS];
    logic [WB-1:0] cursor_reg [MAX_WORKERS];
    logic [IB-1:0] ihead_reg;
    logic [IB:0]   ifill_reg;
    logic [WB-1:0] hturn_reg;
    logic [TB-1:0] total_reg;
    logic [1:0]    state_reg;

    logic [1:0]    st_reg;
    logic          from_inj_reg;
    logic [TASK_BITS-1:0] rd_dq_reg;
    logic [TASK_BITS-1:0] rd_inj_reg;

    // worker count, clamped
    logic [WB:0] wt;
    logic [WB:0] hcount;
    always_comb
    begin
        if (active_workers == 4'd0)
        begin
            wt = (WB+1)'(1);
        end
        else if (32'(active_workers) > MAX_WORKERS)
        begin
            wt = (WB+1)'(MAX_WORKERS);
        end
        else
        begin
            wt = (WB+1)'(active_workers);
        end
        hcount = wt >> 2;
        if (hcount == '0)
        begin
            hcount = (WB+1)'(1);
        end
    end

    // steal victim: rotated search over non-empty deques
    logic [WB-1:0] first;
    logic          victim_ok;
    logic [WB-1:0] victim;
    logic [WB:0]   vtmp;
    always_comb
    begin
        first = cursor_reg[cmd.worker[WB-1:0]];
        if ({1'b0, first} >= wt)
        begin
            first = '0;
        end
        victim_ok = 1'b0;
        victim = '0;
        for (int s = MAX_WORKERS - 1; s >= 0; s--)
        begin
            vtmp = {1'b0, first} + (WB+1)'(s);
            if (vtmp >= wt)
            begin
                vtmp = vtmp - wt;
            end
            if ((WB+1)'(s) < wt && vtmp[WB-1:0] != cmd.worker[WB-1:0]
                && fill_reg[vtmp[WB-1:0]] != '0)
            begin
                victim_ok = 1'b1;
                victim = vtmp[WB-1:0];
            end
        end
    end

    logic [WB-1:0] hidx;
    logic [WB:0]   hnext;
    logic [WB:0]   wrk_w;
    always_comb
    begin
        hidx = hturn_reg;
        if ({1'b0, hturn_reg} >= hcount)
        begin
            hidx = '0;
        end
        hnext = {1'b0, hidx} + 1'b1;
        if (hnext >= hcount)
        begin
            hnext = '0;
        end
        wrk_w = {{(WB+1-3){1'b0}}, cmd.worker} ;
    end

    logic [WB-1:0] tgt;
    logic [DB:0]   tfill;
    logic [DB-1:0] wpos;
    logic [DB-1:0] opos;
    logic [DB-1:0] npos;
    always_comb
    begin
        tgt   = cmd.heavy ? hidx : cmd.worker[WB-1:0];
        tfill = fill_reg[tgt];
        wpos  = head_reg[tgt] + tfill[DB-1:0];
        npos  = head_reg[cmd.worker[WB-1:0]]
                + fill_reg[cmd.worker[WB-1:0]][DB-1:0] - 1'b1;
        opos  = head_reg[victim];
    end

    assign cmd_pop = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_DECIDE;
            ihead_reg <= '0;
            ifill_reg <= '0;
            hturn_reg <= '0;
            total_reg <= '0;
            st_reg    <= wsts_pkg::ST_OK;
            from_inj_reg <= 1'b0;
            done      <= 1'b0;
            given_task <= '0;
            status    <= '0;
            queued_total <= '0;
            for (int w = 0; w < MAX_WORKERS; w++)
            begin
                head_reg[w]   <= '0;
                fill_reg[w]   <= '0;
                cursor_reg[w] <= '0;
            end
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_DECIDE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg <= S_READ;
                        st_reg <= wsts_pkg::ST_OK;
                        from_inj_reg <= 1'b0;
                        case (cmd.op)
                            wsts_pkg::OP_ENQ:
                            begin
                                if (cmd.heavy)
                                begin
                                    hturn_reg <= hnext[WB-1:0];
                                end
                                if (cmd.heavy || cmd.is_worker)
                                begin
                                    if (!cmd.heavy && wrk_w >= wt)
                                    begin
                                        st_reg <= wsts_pkg::ST_NONE;
                                    end
                                    else if (32'(tfill) >= DEQUE_DEPTH)
                                    begin
                                        st_reg <= wsts_pkg::ST_FULL;
                                    end
                                    else
                                    begin
                                        fill_reg[tgt] <= tfill + 1'b1;
                                        total_reg <= total_reg + 1'b1;
                                    end
                                end
                                else if (32'(ifill_reg) >= INJECTOR_DEPTH)
                                begin
                                    st_reg <= wsts_pkg::ST_FULL;
                                end
                                else
                                begin
                                    ifill_reg <= ifill_reg + 1'b1;
                                    total_reg <= total_reg + 1'b1;
                                end
                            end
                            wsts_pkg::OP_TAKE:
                            begin
                                if (wrk_w >= wt)
                                begin
                                    st_reg <= wsts_pkg::ST_NONE;
                                end
                                else if (fill_reg[cmd.worker[WB-1:0]] != '0)
                                begin
                                    fill_reg[cmd.worker[WB-1:0]] <=
                                        fill_reg[cmd.worker[WB-1:0]] - 1'b1;
                                    total_reg <= total_reg - 1'b1;
                                end
                                else if (ifill_reg != '0)
                                begin
                                    from_inj_reg <= 1'b1;
                                    ihead_reg <= ihead_reg + 1'b1;
                                    ifill_reg <= ifill_reg - 1'b1;
                                    total_reg <= total_reg - 1'b1;
                                end
                                else
                                begin
                                    if (wt > (WB+1)'(1))
                                    begin
                                        cursor_reg[cmd.worker[WB-1:0]] <=
                                            ({1'b0, first} + 1'b1 >= wt) ? '0
                                            : first + 1'b1;
                                    end
                                    if (wt > (WB+1)'(1) && victim_ok)
                                    begin
                                        head_reg[victim] <= opos + 1'b1;
                                        fill_reg[victim] <= fill_reg[victim] - 1'b1;
                                        total_reg <= total_reg - 1'b1;
                                    end
                                    else
                                    begin
                                        st_reg <= wsts_pkg::ST_NONE;
                                    end
                                end
                            end
                            wsts_pkg::OP_CLEAR:
                            begin
                                for (int w = 0; w < MAX_WORKERS; w++)
                                begin
                                    head_reg[w] <= '0;
                                    fill_reg[w] <= '0;
                                end
                                ihead_reg <= '0;
                                ifill_reg <= '0;
                                total_reg <= '0;
                            end
                            default:
                            begin
                                st_reg <= wsts_pkg::ST_NONE;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    state_reg <= S_DECIDE;
                    done <= 1'b1;
                    status <= st_reg;
                    queued_total <= 8'(total_reg);
                    if (cmd.op == wsts_pkg::OP_TAKE && st_reg == wsts_pkg::ST_OK)
                    begin
                        given_task <= 16'(from_inj_reg ? rd_inj_reg : rd_dq_reg);
                    end
                    else
                    begin
                        given_task <= '0;
                    end
                end
                default:
                begin
                    state_reg <= S_DECIDE;
                end
            endcase
        end
    end

    // memory ports: at most one write and one read per memory in the decide cycle
    logic dq_we;
    logic [WB+DB-1:0] dq_wa;
    logic [WB+DB-1:0] dq_ra;
    logic inj_we;
    logic [IB-1:0] inj_wa;
    always_comb
    begin
        dq_we = (state_reg == S_DECIDE) && cmd_valid && cmd.op == wsts_pkg::OP_ENQ
                && (cmd.heavy || (cmd.is_worker && wrk_w < wt))
                && 32'(tfill) < DEQUE_DEPTH;
        dq_wa = {tgt, wpos};
        inj_we = (state_reg == S_DECIDE) && cmd_valid && cmd.op == wsts_pkg::OP_ENQ
                 && !cmd.heavy && !cmd.is_worker && 32'(ifill_reg) < INJECTOR_DEPTH;
        inj_wa = ihead_reg + ifill_reg[IB-1:0];
        if (fill_reg[cmd.worker[WB-1:0]] != '0)
        begin
            dq_ra = {cmd.worker[WB-1:0], npos};
        end
        else
        begin
            dq_ra = {victim, opos};
        end
    end

    always_ff @(posedge clk)
    begin
        if (dq_we)
        begin
            dq_mem[dq_wa] <= TASK_BITS'(cmd.task_id);
        end
        if (state_reg == S_DECIDE)
        begin
            rd_dq_reg <= dq_mem[dq_ra];
            rd_inj_reg <= inj_mem[ihead_reg];
        end
        if (inj_we)
        begin
            inj_mem[inj_wa] <= TASK_BITS'(cmd.task_id);
        end
    end

endmodule

/* design/work_stealing_task_scheduler_top.sv */
// top level of the work-stealing task scheduler
// done is registered; a command passes the front queue, then the back states decide, read and output
// no new item is taken until the last one has passed the queue hop and the three back steps
// busy is high from the accepting edge until the result is shown; the receiver cannot stall
// reset: all queues empty, cursors and heavy turn zero, active_workers 8
// clear empties queues by zeroing heads and fills; task memories are not cleared and need no pass
module work_stealing_task_scheduler_top
#(
    parameter int DEQUE_DEPTH    = 16,
    parameter int INJECTOR_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [15:0] task_ident,
    input  logic        heavy,
    input  logic        caller_is_worker,
    input  logic [2:0]  worker_id,
    output logic        done,
    output logic [15:0] given_task,
    output logic [1:0]  status,
    output logic [7:0]  queued_total
);

    logic [3:0] workers_reg;
    logic       busy_reg;
    logic       accept;
    logic       q_valid;
    logic       q_pop;
    wsts_pkg::cmd_t in_cmd;
    wsts_pkg::cmd_t q_cmd;

    // one item in flight at a time
    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    always_comb
    begin
        in_cmd.op        = operation;
        in_cmd.task_id   = task_ident;
        in_cmd.heavy     = heavy;
        in_cmd.is_worker = caller_is_worker;
        in_cmd.worker    = worker_id;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            workers_reg <= 4'd8;
            busy_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                workers_reg <= cfg_wdata;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (q_pop)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // front: command queue
    wsts_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_cmd  (in_cmd),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_cmd  (q_cmd)
    );

    // back: queue state and memories
    wsts_back
    #(
        .DEQUE_DEPTH    (DEQUE_DEPTH),
        .INJECTOR_DEPTH (INJECTOR_DEPTH)
    ) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .active_workers (workers_reg),
        .cmd_valid      (q_valid),
        .cmd            (q_cmd),
        .cmd_pop        (q_pop),
        .done           (done),
        .given_task     (given_task),
        .status         (status),
        .queued_total   (queued_total)
    );

    // a done strobe follows every pop
    a_done_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> done)
        else $error("missing done after pop");

    // no take result carries a task with a nonzero status
    a_given_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != wsts_pkg::ST_OK |-> given_task == 16'd0)
        else $error("task given with failing status");

    // every accept raises busy
    a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised");

endmodule

/* tb/sv/wsts_checker.sv */
// predictor and result checker for the work-stealing task scheduler
module wsts_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  operation,
    input  logic [15:0] task_ident,
    input  logic        heavy,
    input  logic        caller_is_worker,
    input  logic [2:0]  worker_id,
    input  logic        done,
    input  logic [15:0] given_task,
    input  logic [1:0]  status,
    input  logic [7:0]  queued_total,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW = wsts_pkg::MAX_WORKERS;
    localparam int DD = 16;
    localparam int ID = 32;
    localparam int QD = 8;

    typedef struct packed {
        logic [15:0] given;
        logic [1:0]  st;
        logic [7:0]  total;
    } answer_t;

    answer_t     due_mem [QD];
    int          due_wr;
    int          due_rd;
    logic [15:0] dq_mem [NW][DD];
    int          dq_head [NW];
    int          dq_fill [NW];
    logic [15:0] inj_mem [ID];
    int          inj_head;
    int          inj_fill;
    int          cursor [NW];
    int          heavy_rr;
    logic [3:0]  workers_reg;

    function automatic int queued_sum();
        int s;
        s = inj_fill;
        for (int w = 0; w < NW; w++) s += dq_fill[w];
        return s;
    endfunction

    function automatic bit push_dq(int w, logic [15:0] t);
        if (dq_fill[w] >= DD) return 0;
        dq_mem[w][(dq_head[w] + dq_fill[w]) % DD] = t;
        dq_fill[w]++;
        return 1;
    endfunction

    function automatic answer_t dispatch(wsts_pkg::cmd_t c);
        answer_t a;
        int wt, hc, idx, first, victim, me;
        bit ok;
        a = '0;
        me = c.worker;
        wt = (workers_reg < 1) ? 1 : (workers_reg > NW) ? NW : workers_reg;
        case (c.op)
            wsts_pkg::OP_ENQ:
            begin
                if (c.heavy)
                begin
                    hc = wt / wsts_pkg::HEAVY_DIVISOR;
                    if (hc < 1) hc = 1;
                    idx = heavy_rr % hc;
                    heavy_rr = (idx + 1) % hc;
                    a.st = push_dq(idx, c.task_id) ? wsts_pkg::ST_OK : wsts_pkg::ST_FULL;
                end
                else if (c.is_worker)
                begin
                    if (me >= wt) a.st = wsts_pkg::ST_NONE;
                    else a.st = push_dq(me, c.task_id) ? wsts_pkg::ST_OK : wsts_pkg::ST_FULL;
                end
                else if (inj_fill >= ID) a.st = wsts_pkg::ST_FULL;
                else
                begin
                    inj_mem[(inj_head + inj_fill) % ID] = c.task_id;
                    inj_fill++;
                end
            end
            wsts_pkg::OP_TAKE:
            begin
                if (me >= wt) a.st = wsts_pkg::ST_NONE;
                else
                begin
                    ok = 0;
                    if (dq_fill[me] > 0)
                    begin
                        dq_fill[me]--;
                        a.given = dq_mem[me][(dq_head[me] + dq_fill[me]) % DD];
                        ok = 1;
                    end
                    else if (inj_fill > 0)
                    begin
                        a.given = inj_mem[inj_head];
                        inj_head = (inj_head + 1) % ID;
                        inj_fill--;
                        ok = 1;
                    end
                    else if (wt > 1)
                    begin
                        first = (cursor[me] >= wt) ? 0 : cursor[me];
                        cursor[me] = (first + 1) % wt;
                        victim = first;
                        for (int s = 0; s < wt && !ok; s++)
                        begin
                            if (victim != me && dq_fill[victim] > 0)
                            begin
                                a.given = dq_mem[victim][dq_head[victim]];
                                dq_head[victim] = (dq_head[victim] + 1) % DD;
                                dq_fill[victim]--;
                                ok = 1;
                            end
                            victim = (victim + 1) % wt;
                        end
                    end
                    if (!ok)
                    begin
                        a.given = '0;
                        a.st = wsts_pkg::ST_NONE;
                    end
                end
            end
            wsts_pkg::OP_CLEAR:
            begin
                for (int w = 0; w < NW; w++)
                begin
                    dq_head[w] = 0;
                    dq_fill[w] = 0;
                end
                inj_head = 0;
                inj_fill = 0;
            end
            default: a.st = wsts_pkg::ST_NONE;
        endcase
        a.total = 8'(queued_sum());
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        due_wr = 0;
        due_rd = 0;
        for (int w = 0; w < NW; w++)
        begin
            dq_head[w] = 0;
            dq_fill[w] = 0;
            cursor[w] = 0;
        end
        inj_head = 0;
        inj_fill = 0;
        heavy_rr = 0;
        workers_reg = 4'd8;
    end

    assign pending_count = due_wr - due_rd;

    always @(posedge clk)
    begin
        answer_t a;
        wsts_pkg::cmd_t c;
        if (rst_n)
        begin
            if (done)
            begin
                if (due_wr == due_rd)
                begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else
                begin
                    a = due_mem[due_rd % QD];
                    due_rd++;
                    if (given_task !== a.given) report_mismatch("given_task", given_task, a.given);
                    if (status !== a.st) report_mismatch("status", status, a.st);
                    if (queued_total !== a.total)
                        report_mismatch("queued_total", queued_total, a.total);
                end
            end
            if (cfg_we) workers_reg = cfg_wdata;
            if (start && !busy)
            begin
                c = '{operation, task_ident, heavy, caller_is_worker, worker_id};
                due_mem[due_wr % QD] = dispatch(c);
                due_wr++;
            end
        end
    end
endmodule

/* tb/sv/tb.sv */
// stimulus and verdict for the work-stealing task scheduler
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [3:0]  cfg_wdata = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  operation = 0;
    logic [15:0] task_ident = 0;
    logic        heavy = 0;
    logic        caller_is_worker = 0;
    logic [2:0]  worker_id = 0;
    logic        done;
    logic [15:0] given_task;
    logic [1:0]  status;
    logic [7:0]  queued_total;
    int          fail_count;
    int          pending_count;
    int          idle_cycles = 0;
    bit          gaps_on = 0;

    always #5 clk = ~clk;

    work_stealing_task_scheduler_top u_dut (.*);
    wsts_checker u_chk (.*);

    // watchdog: cycles with nothing accepted on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("[work_stealing_task_scheduler_top] ERROR");
            $finish;
        end
    end

    // one item: hold start until the block takes it, then maybe leave a gap
    task automatic issue(logic [1:0] op, logic [15:0] t, logic hv, logic wk, logic [2:0] w);
        start <= 1;
        operation <= op;
        task_ident <= t;
        heavy <= hv;
        caller_is_worker <= wk;
        worker_id <= w;
        do @(posedge clk); while (busy);
        // the item was taken at this edge; busy covers the next cycle anyway
        start <= 0;
        @(posedge clk);
        if (gaps_on && $urandom_range(99) < 32)
        begin
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // let the expected results drain, then write the worker count
    task automatic set_workers(logic [3:0] v);
        while (pending_count != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // mostly enqueue and take, so queues fill up and stealing happens
    task automatic random_item(int bias);
        int r;
        logic [1:0] op;
        r = $urandom_range(99);
        if (r < bias) op = wsts_pkg::OP_ENQ;
        else if (r < 97) op = wsts_pkg::OP_TAKE;
        else if (r < 99) op = wsts_pkg::OP_CLEAR;
        else op = wsts_pkg::OP_RSVD;
        issue(op, 16'($urandom), 1'($urandom_range(99) < 20), 1'($urandom_range(1)),
              3'($urandom));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every operation, bad worker, full queues, stealing
        issue(wsts_pkg::OP_TAKE, 16'd0, 1'b0, 1'b0, 3'd0);     // nothing anywhere
        issue(wsts_pkg::OP_ENQ, 16'hFFFF, 1'b0, 1'b1, 3'd7);
        issue(wsts_pkg::OP_ENQ, 16'h0000, 1'b0, 1'b0, 3'd0);
        issue(wsts_pkg::OP_ENQ, 16'hA5A5, 1'b1, 1'b0, 3'd0);   // heavy
        issue(wsts_pkg::OP_TAKE, 16'd0, 1'b0, 1'b0, 3'd2);     // from injector
        issue(wsts_pkg::OP_TAKE, 16'd0, 1'b0, 1'b0, 3'd2);     // steal
        issue(wsts_pkg::OP_TAKE, 16'd0, 1'b0, 1'b0, 3'd7);     // own deque
        issue(wsts_pkg::OP_RSVD, 16'h1234, 1'b1, 1'b1, 3'd5);  // undefined operation
        issue(wsts_pkg::OP_CLEAR, 16'd0, 1'b0, 1'b0, 3'd0);
        set_workers(4'd3);
        issue(wsts_pkg::OP_ENQ, 16'h5A5A, 1'b0, 1'b1, 3'd6);   // bad worker
        issue(wsts_pkg::OP_TAKE, 16'd0, 1'b0, 1'b0, 3'd5);
        for (int i = 0; i < 17; i++)                           // deque full
            issue(wsts_pkg::OP_ENQ, 16'(i), 1'b0, 1'b1, 3'd1);
        set_workers(4'd0);                                     // acts as one worker
        for (int i = 0; i < 3; i++) issue(wsts_pkg::OP_TAKE, 16'd0, 1'b0, 1'b0, 3'd0);
        set_workers(4'd15);                                    // clamped to eight
        for (int i = 0; i < 33; i++)                           // injector full
            issue(wsts_pkg::OP_ENQ, 16'(~i), 1'b0, 1'b0, 3'd0);
        issue(wsts_pkg::OP_CLEAR, 16'd0, 1'b0, 1'b0, 3'd0);

        // random phases across worker counts, first without gaps
        for (int p = 0; p < 10; p++)
        begin
            set_workers(p == 0 ? 4'd8 : p == 1 ? 4'd1 : 4'($urandom_range(15)));
            gaps_on = (p != 0);
            for (int i = 0; i < 78; i++) random_item(p % 2 ? 60 : 48);
            if (p == 4)
            begin
                // hold off until every expected result is back
                while (pending_count != 0) @(posedge clk);
            end
        end

        while (pending_count != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0) $display("[work_stealing_task_scheduler_top] OK");
        else $display("[work_stealing_task_scheduler_top] ERROR");
        $finish;
    end
endmodule
